@@ rtl/ccbus_pkg.sv @@
`default_nettype none

package ccbus_pkg;

   // work ram: power of two depth, mirrored through 0x0000-0x1fff
   localparam int RAM_AW    = 11;
   localparam int RAM_DEPTH = 1 << RAM_AW;

   localparam logic [15:0] RAM_MIRROR_END = 16'h1FFF;
   localparam logic [15:0] PPU_MIRROR_END = 16'h3FFF;
   localparam logic [15:0] APU_FIRST      = 16'h4000;
   localparam logic [15:0] DMA_START_ADDR = 16'h4014;
   localparam logic [15:0] APU_STATUS     = 16'h4015;
   localparam logic [15:0] PAD0_ADDR      = 16'h4016;
   localparam logic [15:0] PAD1_ADDR      = 16'h4017;
   localparam logic [15:0] PPU_OAM_DATA   = 16'h0004;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_READ    = 2'd1,
      CMD_WRITE   = 2'd2,
      CMD_APU_IRQ = 2'd3
   } command_type;

   typedef enum logic [3:0] {
      TGT_NONE = 4'd0,
      TGT_CART = 4'd1,
      TGT_RAM  = 4'd2,
      TGT_PPU  = 4'd3,
      TGT_APU  = 4'd4,
      TGT_PAD0 = 4'd5,
      TGT_PAD1 = 4'd6,
      TGT_PADS = 4'd7,
      TGT_DMA  = 4'd8
   } target_type;

   typedef struct packed {
      target_type  target;
      logic [15:0] dev_addr;
   } decode_type;

endpackage

`default_nettype wire

@@ rtl/ccbus_decode.sv @@
`default_nettype none

module ccbus_decode
   import ccbus_pkg::*;
(
   input  wire logic [15:0] address,
   input  wire logic        is_write,
   input  wire logic        claim,
   output decode_type       dec
);

   always_comb begin
      dec.target   = TGT_NONE;
      dec.dev_addr = address;
      if (claim) begin
         dec.target = TGT_CART;
      end else if (address <= RAM_MIRROR_END) begin
         dec.target   = TGT_RAM;
         dec.dev_addr = {{(16 - RAM_AW){1'b0}}, address[RAM_AW-1:0]};
      end else if (address <= PPU_MIRROR_END) begin
         dec.target   = TGT_PPU;
         dec.dev_addr = {13'd0, address[2:0]};
      end else if (is_write) begin
         if (address == DMA_START_ADDR) begin
            dec.target = TGT_DMA;
         end else if (address == PAD0_ADDR) begin
            dec.target = TGT_PADS;
         end else if (address >= APU_FIRST && address <= PAD1_ADDR) begin
            dec.target = TGT_APU;
         end
      end else begin
         if (address == PAD0_ADDR) begin
            dec.target = TGT_PAD0;
         end else if (address == APU_STATUS) begin
            dec.target = TGT_APU;
         end else if (address == PAD1_ADDR) begin
            dec.target = TGT_PAD1;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/console_cpu_bus_with_sprite_dma_top.sv @@
`default_nettype none

// a transaction is registered in the first stage and then in the result stage
// throughput: one transaction per cycle unless rsp_ready stalls; the single work
// ram port is read at accept; its registered data joins the result stage
// reset: synchronous, clears phase, dma, irq levels and valid flags
// work ram contents are undefined after reset until written

module console_cpu_bus_with_sprite_dma_top
   import ccbus_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [15:0] req_address,
   input  wire logic [7:0]  req_data,
   input  wire logic        req_cart_claims,
   input  wire logic [7:0]  req_device_read_data,
   input  wire logic        req_cart_irq,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_target,
   output logic             rsp_is_write,
   output logic [15:0]      rsp_device_address,
   output logic [7:0]       rsp_write_data,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_cpu_step,
   output logic             rsp_apu_step,
   output logic             rsp_dma_busy,
   output logic             rsp_irq_out
);

   localparam logic [2:0] PHASE_A    = 3'd0;
   localparam logic [2:0] PHASE_B    = 3'd3;
   localparam logic [2:0] PHASE_LAST = 3'd5;

   // machine state
   logic [2:0] phase_ff, phase_in;
   logic       dma_active_ff, dma_active_in;
   logic       dma_align_ff, dma_align_in;
   logic [7:0] src_page_ff, src_page_in;
   logic [7:0] dma_offset_ff, dma_offset_in;
   logic [7:0] dma_latched_ff, dma_latched_in;
   logic       latch_pend_ff, latch_pend_in;
   logic       apu_irq_ff, apu_irq_in;
   logic       cart_irq_ff, cart_irq_in;

   // first stage
   logic       s1_valid_ff;
   target_type s1_target_ff, s1_target_in;
   logic       s1_wr_ff, s1_wr_in;
   logic [15:0] s1_dev_ff, s1_dev_in;
   logic [7:0] s1_wd_ff, s1_wd_in;
   logic [7:0] s1_rd_ff, s1_rd_in;
   logic       s1_rd_ram_ff, s1_rd_ram_in;
   logic       s1_cpu_ff, s1_cpu_in;
   logic       s1_apu_ff, s1_apu_in;
   logic       s1_busy_ff;
   logic       s1_irq_ff;

   // result stage
   logic       out_valid_ff;
   target_type out_target_ff;
   logic       out_wr_ff;
   logic [15:0] out_dev_ff;
   logic [7:0] out_wd_ff;
   logic [7:0] out_rd_ff;
   logic       out_cpu_ff;
   logic       out_apu_ff;
   logic       out_busy_ff;
   logic       out_irq_ff;

   logic [7:0] ram_mem [RAM_DEPTH];
   logic [7:0] ram_rdata_ff;

   logic        accept;
   logic        s1_move;
   command_type cmd;
   logic [15:0] bus_addr;
   decode_type  dec;
   logic        active_phase;
   logic [7:0]  ext_rd;
   logic        ram_rd_en;
   logic        ram_wr_en;
   logic [RAM_AW-1:0] ram_idx;

   assign s1_move   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;
   assign cmd       = command_type'(req_command);

   // the dma read slot shares the decoder with cpu reads
   assign bus_addr = (cmd == CMD_TICK) ? {src_page_ff, dma_offset_ff} : req_address;

   ccbus_decode u_decode (
      .address  (bus_addr),
      .is_write (cmd == CMD_WRITE),
      .claim    (req_cart_claims),
      .dec      (dec)
   );

   assign active_phase = (phase_ff == PHASE_A) || (phase_ff == PHASE_B);
   assign ext_rd       = (dec.target == TGT_NONE) ? 8'd0 : req_device_read_data;
   assign ram_idx      = dec.dev_addr[RAM_AW-1:0];

   always_comb begin
      phase_in       = phase_ff;
      dma_active_in  = dma_active_ff;
      dma_align_in   = dma_align_ff;
      src_page_in    = src_page_ff;
      dma_offset_in  = dma_offset_ff;
      dma_latched_in = dma_latched_ff;
      latch_pend_in  = 1'b0;
      apu_irq_in     = apu_irq_ff;
      cart_irq_in    = cart_irq_ff;
      s1_target_in   = TGT_NONE;
      s1_wr_in       = 1'b0;
      s1_dev_in      = 16'd0;
      s1_wd_in       = 8'd0;
      s1_rd_in       = 8'd0;
      s1_rd_ram_in   = 1'b0;
      s1_cpu_in      = 1'b0;
      s1_apu_in      = 1'b0;
      ram_rd_en      = 1'b0;
      ram_wr_en      = 1'b0;

      // ram byte of a dma read arrives in the cycle after the read
      if (latch_pend_ff) begin
         dma_latched_in = ram_rdata_ff;
      end

      if (accept) begin
         unique case (cmd)
            CMD_TICK: begin
               cart_irq_in = req_cart_irq;
               phase_in    = (phase_ff >= PHASE_LAST) ? 3'd0 : phase_ff + 3'd1;
               if (active_phase) begin
                  s1_apu_in = 1'b1;
                  if (!dma_active_ff) begin
                     s1_cpu_in = 1'b1;
                  end else if (dma_align_ff) begin
                     if (phase_ff == PHASE_B) begin
                        dma_align_in = 1'b0;
                     end
                  end else if (phase_ff == PHASE_A) begin
                     s1_target_in = dec.target;
                     s1_dev_in    = dec.dev_addr;
                     if (dec.target == TGT_RAM) begin
                        s1_rd_ram_in  = 1'b1;
                        ram_rd_en     = 1'b1;
                        latch_pend_in = 1'b1;
                     end else begin
                        s1_rd_in       = ext_rd;
                        dma_latched_in = ext_rd;
                     end
                  end else begin
                     s1_target_in  = TGT_PPU;
                     s1_wr_in      = 1'b1;
                     s1_dev_in     = PPU_OAM_DATA;
                     s1_wd_in      = dma_latched_ff;
                     dma_offset_in = dma_offset_ff + 8'd1;
                     if (dma_offset_ff == 8'hFF) begin
                        dma_active_in = 1'b0;
                        dma_align_in  = 1'b1;
                     end
                  end
               end
            end
            CMD_READ: begin
               s1_target_in = dec.target;
               s1_dev_in    = dec.dev_addr;
               if (dec.target == TGT_RAM) begin
                  s1_rd_ram_in = 1'b1;
                  ram_rd_en    = 1'b1;
               end else begin
                  s1_rd_in = ext_rd;
               end
            end
            CMD_WRITE: begin
               s1_wr_in     = 1'b1;
               s1_target_in = dec.target;
               s1_dev_in    = dec.dev_addr;
               s1_wd_in     = (dec.target == TGT_NONE) ? 8'd0 : req_data;
               if (dec.target == TGT_RAM) begin
                  ram_wr_en = 1'b1;
               end
               if (dec.target == TGT_DMA) begin
                  src_page_in   = req_data;
                  dma_offset_in = 8'd0;
                  dma_active_in = 1'b1;
                  dma_align_in  = 1'b1;
               end
            end
            CMD_APU_IRQ: begin
               apu_irq_in = req_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ram_wr_en) begin
         ram_mem[ram_idx] <= req_data;
      end
      if (ram_rd_en) begin
         ram_rdata_ff <= ram_mem[ram_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= 3'd0;
         dma_active_ff  <= 1'b0;
         dma_align_ff   <= 1'b0;
         src_page_ff    <= 8'd0;
         dma_offset_ff  <= 8'd0;
         dma_latched_ff <= 8'd0;
         latch_pend_ff  <= 1'b0;
         apu_irq_ff     <= 1'b0;
         cart_irq_ff    <= 1'b0;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         dma_active_ff  <= dma_active_in;
         dma_align_ff   <= dma_align_in;
         src_page_ff    <= src_page_in;
         dma_offset_ff  <= dma_offset_in;
         dma_latched_ff <= dma_latched_in;
         latch_pend_ff  <= latch_pend_in;
         apu_irq_ff     <= apu_irq_in;
         cart_irq_ff    <= cart_irq_in;
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_target_ff <= s1_target_in;
         s1_wr_ff     <= s1_wr_in;
         s1_dev_ff    <= s1_dev_in;
         s1_wd_ff     <= s1_wd_in;
         s1_rd_ff     <= s1_rd_in;
         s1_rd_ram_ff <= s1_rd_ram_in;
         s1_cpu_ff    <= s1_cpu_in;
         s1_apu_ff    <= s1_apu_in;
         s1_busy_ff   <= dma_active_in;
         s1_irq_ff    <= apu_irq_in || cart_irq_in;
      end
      if (s1_move) begin
         out_target_ff <= s1_target_ff;
         out_wr_ff     <= s1_wr_ff;
         out_dev_ff    <= s1_dev_ff;
         out_wd_ff     <= s1_wd_ff;
         out_rd_ff     <= s1_rd_ram_ff ? ram_rdata_ff : s1_rd_ff;
         out_cpu_ff    <= s1_cpu_ff;
         out_apu_ff    <= s1_apu_ff;
         out_busy_ff   <= s1_busy_ff;
         out_irq_ff    <= s1_irq_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_target         = out_target_ff;
   assign rsp_is_write       = out_wr_ff;
   assign rsp_device_address = out_dev_ff;
   assign rsp_write_data     = out_wd_ff;
   assign rsp_read_data      = out_rd_ff;
   assign rsp_cpu_step       = out_cpu_ff;
   assign rsp_apu_step       = out_apu_ff;
   assign rsp_dma_busy       = out_busy_ff;
   assign rsp_irq_out        = out_irq_ff;

`ifndef NO_ASSERTIONS
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PHASE_LAST)
      else $error("tick phase out of range");

   a_dma_start_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_target == TGT_DMA) |-> rsp_dma_busy)
      else $error("dma start without busy");

   a_cpu_step_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cpu_step |-> !rsp_dma_busy && rsp_apu_step)
      else $error("cpu step while dma busy");

   a_ram_single_port: assert property (@(posedge clock) disable iff (reset)
      !(ram_rd_en && ram_wr_en))
      else $error("ram read and write in one cycle");

   a_latch_pending: assert property (@(posedge clock) disable iff (reset)
      latch_pend_ff |-> dma_active_ff && !dma_align_ff)
      else $error("dma latch pending outside transfer");
`endif

endmodule

`default_nettype wire
